@@ hdl/rbwb_pkg.sv @@
// ----------------------------------------------------------------------------
// rbwb_pkg: shared types and constants
// Register indexes, sine polynomial coefficients and the pipeline carry record.
// ----------------------------------------------------------------------------
package rbwb_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_BOX_OFFSET_X = 8'd0;
    localparam logic [7:0] CFG_BOX_OFFSET_Y = 8'd1;
    localparam logic [7:0] CFG_BOX_SIZE_X   = 8'd2;
    localparam logic [7:0] CFG_BOX_SIZE_Y   = 8'd3;

    // odd Taylor coefficients of sin(pi/2*u), Q30
    localparam logic [30:0] COEF_A1 = 31'd1686629713;
    localparam logic [30:0] COEF_A3 = 31'd693598669;
    localparam logic [30:0] COEF_A5 = 31'd85569306;
    localparam logic [30:0] COEF_A7 = 31'd5026995;
    localparam logic [30:0] COEF_A9 = 31'd172272;

    localparam int QSIN_W = 15;   // quarter-wave magnitude width

    // payload that rides alongside the sine/cosine evaluation
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [1:0]         quad;
        logic signed [48:0] xs0;
        logic signed [48:0] xs1;
        logic signed [48:0] ys0;
        logic signed [48:0] ys1;
    } carry_t;

endpackage

@@ hdl/rbwb_qsin.sv @@
// ----------------------------------------------------------------------------
// rbwb_qsin: pipelined quarter-wave sine
// Horner evaluation of a degree-9 odd polynomial, one multiply per stage up to
// a final rounding stage, seven register stages from u_in to q_out.
// ----------------------------------------------------------------------------
module rbwb_qsin (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [30:0]                    u_in,   // g << 16, g in 0..16384
    output logic [rbwb_pkg::QSIN_W-1:0]    q_out   // Q0.15 magnitude
);

    logic [30:0] u_reg  [2:6];
    logic [30:0] u2_reg [2:5];
    logic [30:0] p_reg  [3:6];
    logic [31:0] r_reg;
    logic [rbwb_pkg::QSIN_W-1:0] q_reg;

    logic [61:0] sq_prod;
    logic [61:0] h_prod [3:6];
    logic [30:0] p_next [3:6];
    logic [61:0] r_prod;
    logic [33:0] rnd_sum;
    logic [17:0] rnd;

    always_comb begin
        sq_prod = u_in * u_in;
        h_prod[3] = rbwb_pkg::COEF_A9 * u2_reg[2];
        p_next[3] = rbwb_pkg::COEF_A7 - h_prod[3][60:30];
        h_prod[4] = p_reg[3] * u2_reg[3];
        p_next[4] = rbwb_pkg::COEF_A5 - h_prod[4][60:30];
        h_prod[5] = p_reg[4] * u2_reg[4];
        p_next[5] = rbwb_pkg::COEF_A3 - h_prod[5][60:30];
        h_prod[6] = p_reg[5] * u2_reg[5];
        p_next[6] = rbwb_pkg::COEF_A1 - h_prod[6][60:30];
        r_prod = p_reg[6] * u_reg[6];
        rnd_sum = {1'b0, r_reg, 1'b0} + 34'd32768;
        rnd = rnd_sum[33:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[2]  <= u_in;
            u2_reg[2] <= sq_prod[60:30];
            for (int k = 3; k <= 6; k++) begin
                u_reg[k] <= u_reg[k-1];
                p_reg[k] <= p_next[k];
            end
            for (int k = 3; k <= 5; k++) begin
                u2_reg[k] <= u2_reg[k-1];
            end
            r_reg <= r_prod[61:30];
            // round half up, clamp just below one
            if (rnd > 18'd32767) begin
                q_reg <= 15'h7FFF;
            end else begin
                q_reg <= rnd[rbwb_pkg::QSIN_W-1:0];
            end
        end
    end

    assign q_out = q_reg;

endmodule

@@ hdl/rotated_box_world_bounds_core.sv @@
// ----------------------------------------------------------------------------
// rotated_box_world_bounds_core: world AABB of a scaled, rotated box
// Scales the configured local box, rotates it by a fraction-of-turn angle,
// translates it and returns min x/y plus saturated width/height.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_      | in        | pos_x, pos_y, scale_x, scale_y, turn_angle
//  m_      | out       | min_x, min_y, width, height
//  cfg_    | in        | register index, 32-bit data
//
//  One transaction enters per cycle while the stages advance. The depth is set
//  by the sine polynomial: six chained multiplies, one per stage, then a
//  rounding stage.
//  All stages advance together whenever the output register is empty or is
//  being taken; a stall freezes every stage, so nothing is lost or repeated.
//  Reset (aresetn low, synchronous) clears the valid bits and loads the box
//  registers with offset 0 and size 1.0. Configuration is accepted whenever
//  reset is released; no transaction is taken while reset is held.
// ----------------------------------------------------------------------------
module rotated_box_world_bounds_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0], pos_y[63:32], scale_x[79:64], scale_y[95:80],
    // turn_angle[111:96]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // min_x[31:0], min_y[63:32], width[94:64], height[125:95], zero pad
    output logic [127:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_addr,
    input  logic [31:0]  cfg_data
);

    localparam int NST = 13;

    // configuration registers
    logic signed [31:0] off_x_reg, off_y_reg, size_x_reg, size_y_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg  <= 32'sd0;
            off_y_reg  <= 32'sd0;
            size_x_reg <= 32'sd65536;
            size_y_reg <= 32'sd65536;
        end else if (cfg_valid) begin
            case (cfg_addr)
                rbwb_pkg::CFG_BOX_OFFSET_X: off_x_reg  <= cfg_data;
                rbwb_pkg::CFG_BOX_OFFSET_Y: off_y_reg  <= cfg_data;
                rbwb_pkg::CFG_BOX_SIZE_X:   size_x_reg <= cfg_data;
                rbwb_pkg::CFG_BOX_SIZE_Y:   size_y_reg <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // global advance: hold everything while a finished result waits
    logic         en;
    logic [NST:1] vld_reg;

    assign en       = !vld_reg[NST] || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = vld_reg[NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-1:1], s_tvalid};
        end
    end

    // stage 1: unpack, box corners along each axis, polynomial arguments
    logic signed [31:0] px1_reg, py1_reg;
    logic signed [15:0] sx1_reg, sy1_reg;
    logic [1:0]         quad1_reg;
    logic signed [32:0] xa1_reg, xb1_reg, ya1_reg, yb1_reg;
    logic [30:0]        us1_reg, uc1_reg;

    logic [13:0] frac;
    logic [14:0] cfrac;

    always_comb begin
        frac  = s_tdata[109:96];
        cfrac = 15'd16384 - {1'b0, frac};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg   <= s_tdata[31:0];
            py1_reg   <= s_tdata[63:32];
            sx1_reg   <= s_tdata[79:64];
            sy1_reg   <= s_tdata[95:80];
            quad1_reg <= s_tdata[111:110];
            xa1_reg   <= {off_x_reg[31], off_x_reg};
            xb1_reg   <= {off_x_reg[31], off_x_reg} + {size_x_reg[31], size_x_reg};
            ya1_reg   <= {off_y_reg[31], off_y_reg};
            yb1_reg   <= {off_y_reg[31], off_y_reg} + {size_y_reg[31], size_y_reg};
            us1_reg   <= {1'b0, frac, 16'd0};
            uc1_reg   <= {cfrac, 16'd0};
        end
    end

    // stages 2..8: sine and cosine magnitudes
    logic [rbwb_pkg::QSIN_W-1:0] s0_q, c0_q;

    rbwb_qsin u_sin (.aclk(aclk), .en(en), .u_in(us1_reg), .q_out(s0_q));
    rbwb_qsin u_cos (.aclk(aclk), .en(en), .u_in(uc1_reg), .q_out(c0_q));

    // stage 2: scaled corners, then delay alongside the polynomial
    rbwb_pkg::carry_t car_reg [2:9];
    rbwb_pkg::carry_t car_next;

    always_comb begin
        car_next.px   = px1_reg;
        car_next.py   = py1_reg;
        car_next.quad = quad1_reg;
        car_next.xs0  = xa1_reg * sx1_reg;
        car_next.xs1  = xb1_reg * sx1_reg;
        car_next.ys0  = ya1_reg * sy1_reg;
        car_next.ys1  = yb1_reg * sy1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car_reg[2] <= car_next;
            for (int k = 3; k <= 9; k++) begin
                car_reg[k] <= car_reg[k-1];
            end
        end
    end

    // stage 9: fold quadrant into signed sine/cosine
    logic signed [16:0] sn9_reg, cs9_reg, sn_next, cs_next;
    logic signed [16:0] s0s, c0s;

    always_comb begin
        s0s = {2'b00, s0_q};
        c0s = {2'b00, c0_q};
        case (car_reg[8].quad)
            2'd0: begin sn_next = s0s;  cs_next = c0s;  end
            2'd1: begin sn_next = c0s;  cs_next = -s0s; end
            2'd2: begin sn_next = -s0s; cs_next = -c0s; end
            default: begin sn_next = -c0s; cs_next = s0s; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sn9_reg <= sn_next;
            cs9_reg <= cs_next;
        end
    end

    // stage 10: rotation partial products
    logic signed [65:0] xc10_reg [2], xs10_reg [2], yc10_reg [2], ys10_reg [2];
    logic signed [31:0] px10_reg, py10_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xc10_reg[0] <= car_reg[9].xs0 * cs9_reg;
            xc10_reg[1] <= car_reg[9].xs1 * cs9_reg;
            xs10_reg[0] <= car_reg[9].xs0 * sn9_reg;
            xs10_reg[1] <= car_reg[9].xs1 * sn9_reg;
            yc10_reg[0] <= car_reg[9].ys0 * cs9_reg;
            yc10_reg[1] <= car_reg[9].ys1 * cs9_reg;
            ys10_reg[0] <= car_reg[9].ys0 * sn9_reg;
            ys10_reg[1] <= car_reg[9].ys1 * sn9_reg;
            px10_reg    <= car_reg[9].px;
            py10_reg    <= car_reg[9].py;
        end
    end

    // stage 11: combine, round half up to Q16.16, translate
    logic signed [41:0] wx11_reg [4], wy11_reg [4];
    logic signed [41:0] wx_next [4], wy_next [4];
    logic signed [66:0] rx [4], ry [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            // corner order (x,y): (0,0) (1,0) (1,1) (0,1)
            rx[k] = xc10_reg[(k == 1 || k == 2) ? 1 : 0]
                  - ys10_reg[(k >= 2) ? 1 : 0] + 67'sd4194304;
            ry[k] = xs10_reg[(k == 1 || k == 2) ? 1 : 0]
                  + yc10_reg[(k >= 2) ? 1 : 0] + 67'sd4194304;
            wx_next[k] = rx[k][64:23] + {{10{px10_reg[31]}}, px10_reg};
            wy_next[k] = ry[k][64:23] + {{10{py10_reg[31]}}, py10_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wx11_reg <= wx_next;
            wy11_reg <= wy_next;
        end
    end

    // stage 12: min and max over the four corners
    logic signed [41:0] mnx12_reg, mxx12_reg, mny12_reg, mxy12_reg;
    logic signed [41:0] mnx_a, mnx_b, mxx_a, mxx_b, mny_a, mny_b, mxy_a, mxy_b;

    always_comb begin
        mnx_a = (wx11_reg[0] < wx11_reg[1]) ? wx11_reg[0] : wx11_reg[1];
        mnx_b = (wx11_reg[2] < wx11_reg[3]) ? wx11_reg[2] : wx11_reg[3];
        mxx_a = (wx11_reg[0] > wx11_reg[1]) ? wx11_reg[0] : wx11_reg[1];
        mxx_b = (wx11_reg[2] > wx11_reg[3]) ? wx11_reg[2] : wx11_reg[3];
        mny_a = (wy11_reg[0] < wy11_reg[1]) ? wy11_reg[0] : wy11_reg[1];
        mny_b = (wy11_reg[2] < wy11_reg[3]) ? wy11_reg[2] : wy11_reg[3];
        mxy_a = (wy11_reg[0] > wy11_reg[1]) ? wy11_reg[0] : wy11_reg[1];
        mxy_b = (wy11_reg[2] > wy11_reg[3]) ? wy11_reg[2] : wy11_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mnx12_reg <= (mnx_a < mnx_b) ? mnx_a : mnx_b;
            mxx12_reg <= (mxx_a > mxx_b) ? mxx_a : mxx_b;
            mny12_reg <= (mny_a < mny_b) ? mny_a : mny_b;
            mxy12_reg <= (mxy_a > mxy_b) ? mxy_a : mxy_b;
        end
    end

    // stage 13: saturate into the output register
    logic [31:0] min_x_reg, min_y_reg, min_x_next, min_y_next;
    logic [30:0] width_reg, height_reg, width_next, height_next;
    logic [42:0] span_x, span_y;

    function automatic logic [31:0] sat_coord(input logic signed [41:0] v);
        logic [10:0] top;
        begin
            top = v[41:31];
            if (top == 11'd0 || top == 11'h7FF) begin
                sat_coord = v[31:0];
            end else if (v[41]) begin
                sat_coord = 32'h8000_0000;
            end else begin
                sat_coord = 32'h7FFF_FFFF;
            end
        end
    endfunction

    always_comb begin
        min_x_next  = sat_coord(mnx12_reg);
        min_y_next  = sat_coord(mny12_reg);
        span_x      = {mxx12_reg[41], mxx12_reg} - {mnx12_reg[41], mnx12_reg};
        span_y      = {mxy12_reg[41], mxy12_reg} - {mny12_reg[41], mny12_reg};
        width_next  = (span_x[42:31] != 12'd0) ? 31'h7FFF_FFFF : span_x[30:0];
        height_next = (span_y[42:31] != 12'd0) ? 31'h7FFF_FFFF : span_y[30:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            min_x_reg  <= min_x_next;
            min_y_reg  <= min_y_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign m_tdata = {2'b00, height_reg, width_reg, min_y_reg, min_x_reg};

endmodule

@@ dv/rotated_box_world_bounds_core_tb.sv @@
// ----------------------------------------------------------------------------
// rotated_box_world_bounds_core_tb: self-checking bench for the bounds core
// Streams object transforms through the core under several idle/stall phases
// and box settings, and checks every bounding box against a local predictor.
// ----------------------------------------------------------------------------
module rotated_box_world_bounds_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIN = 32767;
    localparam logic [7:0] CFG_UNUSED = 8'd9;   // index outside the register map

    typedef struct packed {
        logic [15:0]        ang;
        logic signed [15:0] sy;
        logic signed [15:0] sx;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } xform_t;

    typedef struct packed {
        logic [30:0]        h;
        logic [30:0]        w;
        logic signed [31:0] mny;
        logic signed [31:0] mnx;
    } bounds_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_addr = '0;
    logic [31:0]  cfg_data = '0;

    rotated_box_world_bounds_core i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor copy of the box registers
    longint box_ox = 0, box_oy = 0, box_sx = 65536, box_sy = 65536;

    xform_t  xform_q[$];
    bounds_t bounds_q[$];
    int      err_cnt = 0;
    int      out_cnt = 0;
    int      src_idle = 0;   // percent of cycles the source holds off
    int      snk_stall = 0;  // percent of cycles the sink stalls

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH %s at result %0d: got %0h expected %0h", what, out_cnt, got, exp);
        err_cnt++;
    endtask

    function automatic longint quarter_wave(input int unsigned g);
        longint unsigned u, u2, p, r;
        u  = longint'(g) << 16;
        u2 = (u * u) >> 30;
        p  = 64'(rbwb_pkg::COEF_A9);
        p  = 64'(rbwb_pkg::COEF_A7) - ((p * u2) >> 30);
        p  = 64'(rbwb_pkg::COEF_A5) - ((p * u2) >> 30);
        p  = 64'(rbwb_pkg::COEF_A3) - ((p * u2) >> 30);
        p  = 64'(rbwb_pkg::COEF_A1) - ((p * u2) >> 30);
        r  = (p * u) >> 30;
        r  = (r + 64'd16384) >> 15;
        if (r > 64'(MAX_SIN)) r = 64'(MAX_SIN);
        return longint'(r);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_span(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < 0) return 0;
        return v;
    endfunction

    function automatic bounds_t world_bounds(input xform_t t);
        longint s0, c0, sn, cs, cx, cy, rx, ry, wx, wy;
        longint mnx, mny, mxx, mxy;
        longint xs[2], ys[2];
        bounds_t b;
        s0 = quarter_wave(t.ang[13:0]);
        c0 = quarter_wave(16384 - t.ang[13:0]);
        case (t.ang[15:14])
            2'd0: begin sn = s0;  cs = c0;  end
            2'd1: begin sn = c0;  cs = -s0; end
            2'd2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
        xs[0] = box_ox * longint'(t.sx);
        xs[1] = (box_ox + box_sx) * longint'(t.sx);
        ys[0] = box_oy * longint'(t.sy);
        ys[1] = (box_oy + box_sy) * longint'(t.sy);
        for (int k = 0; k < 4; k++) begin
            cx = xs[(k == 1 || k == 2) ? 1 : 0];
            cy = ys[(k >= 2) ? 1 : 0];
            rx = cx * cs - cy * sn;
            ry = cx * sn + cy * cs;
            // arithmetic shift is floor division, so this rounds half up
            wx = longint'(t.px) + ((rx + (64'sd1 <<< 22)) >>> 23);
            wy = longint'(t.py) + ((ry + (64'sd1 <<< 22)) >>> 23);
            if (k == 0 || wx < mnx) mnx = wx;
            if (k == 0 || wx > mxx) mxx = wx;
            if (k == 0 || wy < mny) mny = wy;
            if (k == 0 || wy > mxy) mxy = wy;
        end
        b.mnx = 32'(clamp32(mnx));
        b.mny = 32'(clamp32(mny));
        b.w   = 31'(clamp_span(mxx - mnx));
        b.h   = 31'(clamp_span(mxy - mny));
        return b;
    endfunction

    // Driver: present the head of the pending queue; advance on each accepted
    // transaction and hold the payload steady while stalled.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                bounds_q.push_back(world_bounds(xform_q.pop_front()));
            end
            if ((!s_tvalid || s_tready) ) begin
                if (xform_q.size() != 0 && $urandom_range(99) >= src_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= xform_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        bounds_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = bounds_t'(m_tdata[125:0]);
            if (bounds_q.size() == 0) begin
                report_mismatch("unexpected result", got.mnx, 0);
            end else begin
                exp = bounds_q.pop_front();
                if (got.mnx !== exp.mnx) report_mismatch("min_x", got.mnx, exp.mnx);
                if (got.mny !== exp.mny) report_mismatch("min_y", got.mny, exp.mny);
                if (got.w !== exp.w) report_mismatch("width", got.w, exp.w);
                if (got.h !== exp.h) report_mismatch("height", got.h, exp.h);
            end
            if (m_tdata[127:126] !== 2'b00) report_mismatch("pad", m_tdata[127:126], 0);
            out_cnt++;
        end
    end

    // Write one box register; only called while the pipeline is drained.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rbwb_pkg::CFG_BOX_OFFSET_X: box_ox = longint'(signed'(val));
            rbwb_pkg::CFG_BOX_OFFSET_Y: box_oy = longint'(signed'(val));
            rbwb_pkg::CFG_BOX_SIZE_X:   box_sx = longint'(signed'(val));
            rbwb_pkg::CFG_BOX_SIZE_Y:   box_sy = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] ox, oy, sx, sy);
        write_reg(rbwb_pkg::CFG_BOX_OFFSET_X, ox);
        write_reg(rbwb_pkg::CFG_BOX_OFFSET_Y, oy);
        write_reg(rbwb_pkg::CFG_BOX_SIZE_X, sx);
        write_reg(rbwb_pkg::CFG_BOX_SIZE_Y, sy);
    endtask

    // Block until every queued item went in and every result came out.
    task automatic drain();
        while (xform_q.size() != 0 || bounds_q.size() != 0 || s_tvalid) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic xform_t rand_xform();
        xform_t t;
        t = 112'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(3))
            0: begin   // typical: moderate position and scale
                t.px = $signed($urandom_range(2000000)) - 1000000;
                t.py = $signed($urandom_range(2000000)) - 1000000;
                t.sx = $signed($urandom_range(1024)) - 512;
                t.sy = $signed($urandom_range(1024)) - 512;
            end
            1: begin   // quadrant boundaries and their neighbours
                t.ang = {$urandom_range(3), 14'd0} + $urandom_range(2) - 1;
            end
            default: ;
        endcase
        return t;
    endfunction

    initial begin : stimulus
        xform_t t;
        logic [31:0] extremes[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset box, identity, extremes, each quadrant
        xform_q.push_back('{ang: 0, sy: 256, sx: 256, py: 0, px: 0});
        for (int q = 0; q < 4; q++) begin
            xform_q.push_back('{ang: q * 16384, sy: 256, sx: 256, py: 100, px: -100});
            xform_q.push_back('{ang: q * 16384 + 8192, sy: -256, sx: 512, py: 0, px: 0});
        end
        xform_q.push_back('{ang: 16'hFFFF, sy: 16'h7FFF, sx: 16'h7FFF,
                            py: 32'h7FFF_FFFF, px: 32'h7FFF_FFFF});
        xform_q.push_back('{ang: 16'h4000, sy: 16'h8000, sx: 16'h8000,
                            py: 32'h8000_0000, px: 32'h8000_0000});
        drain();
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);   // ignored index
        set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 8; i++) begin
            t = rand_xform();
            t.sx = extremes[i % 4][15:0];
            t.sy = extremes[(i + 1) % 4][15:0];
            xform_q.push_back(t);
        end
        drain();

        // random phases: idle/stall mix and a fresh box each
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 81; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 81; end
                default: begin src_idle = 15; snk_stall = 15; end
            endcase
            if (ph == 4) set_box(extremes[0], extremes[0], extremes[0], extremes[0]);
            else if (ph == 5) set_box(extremes[1], extremes[1], extremes[1], extremes[1]);
            else if (ph % 2 == 0)
                set_box($signed($urandom_range(400000)) - 200000,
                        $signed($urandom_range(400000)) - 200000,
                        $signed($urandom_range(600000)) - 200000,
                        $signed($urandom_range(600000)) - 200000);
            else set_box($urandom, $urandom, $urandom, $urandom);
            for (int i = 0; i < 153; i++) xform_q.push_back(rand_xform());
            drain();
        end

        $display("Covered %0d results across 8 idle/stall phases and 10 box settings,",
                 out_cnt);
        $display("including all quadrants, saturating extremes and an ignored write.");
        if (err_cnt == 0 && bounds_q.size() == 0) begin
            $display("rotated_box_world_bounds_core_tb OK");
        end else begin
            $display("rotated_box_world_bounds_core_tb NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("rotated_box_world_bounds_core_tb NOT OK");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/rbwb_pkg.sv
hdl/rbwb_qsin.sv
hdl/rotated_box_world_bounds_core.sv
dv/rotated_box_world_bounds_core_tb.sv
